// ===== rtl/hiet_pkg.sv =====
// types, codes and constants shared by the hid input event tracker
package hiet_pkg;

	localparam int KEY_COUNT_DEF = 256;
	localparam int BTN_COUNT     = 6;
	localparam int BTN_PAIRS     = 3;
	localparam int WHEEL_BIT     = 10;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 15;

	typedef enum logic [1:0] {
		REQ_KEYBOARD = 2'd0,
		REQ_MOUSE    = 2'd1,
		REQ_FRAME    = 2'd2,
		REQ_QUERY    = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		EV_KEY_PRESSED = 3'd0,
		EV_KEY_RELEASED = 3'd1,
		EV_BTN_PRESSED = 3'd2,
		EV_BTN_RELEASED = 3'd3,
		EV_STATUS = 3'd4
	} ev_kind_t;

	localparam logic [2:0] KEY_MAKE  = 3'd0;
	localparam logic [2:0] KEY_BREAK = 3'd1;

	localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT = 2'd1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         key_code;
		logic [2:0]         key_flags;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic [15:0]        button_flags;
		logic signed [15:0] wheel_data;
	} req_t;

	typedef struct packed {
		logic [2:0]         event_kind;
		logic [7:0]         event_key;
		logic [2:0]         button_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] rel_x;
		logic signed [15:0] rel_y;
		logic signed [15:0] wheel;
		logic               key_is_down;
		logic               last;
	} evt_t;

endpackage

// ===== rtl/hid_input_event_tracker.sv =====
// hid input event tracker: key table, bounded pointer position and button trackers
//
// Items enter an input register one per cycle, unless the previous item's results are still
// being sent, and are applied to the tracked state in one pass; their results (one to seven
// words: an optional key event, up to six button events in tracker order, then a status word
// marked last) leave through a single output register one word per cycle while evt_ready
// allows. An item therefore holds the output until all of its results are sent, and the next
// item is applied in the cycle its predecessor's status word is loaded. The key table is
// cleared at once by reset; keys at or above KEY_COUNT are never stored and read as up.
module hid_input_event_tracker #(
	parameter int KEY_COUNT = hiet_pkg::KEY_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  hiet_pkg::req_t                      req,
	output logic                                evt_valid,
	input  logic                                evt_ready,
	output hiet_pkg::evt_t                      evt,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hiet_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [hiet_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int TABLE_DEPTH = (KEY_COUNT < 256) ? KEY_COUNT : 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [16:0] KEY_LIMIT = 17'(KEY_COUNT);

	function automatic logic signed [15:0] bounded_add(input logic signed [15:0] pos,
			input logic signed [15:0] off, input logic [14:0] half);
		logic signed [16:0] np;
		logic signed [16:0] h;
		np = {pos[15], pos} + {off[15], off};
		h = {2'b00, half};
		if (np > h || np < -h) begin
			return pos;
		end
		return np[15:0];
	endfunction

	function automatic logic [2:0] first_pend(input logic [hiet_pkg::BTN_COUNT-1:0] p);
		logic [2:0] idx;
		idx = '0;
		for (int i = hiet_pkg::BTN_COUNT - 1; i >= 0; i--) begin
			if (p[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	// configuration
	logic [14:0] half_w_q, half_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= 15'h7fff;
			half_h_q <= 15'h7fff;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hiet_pkg::REG_HALF_WIDTH:  half_w_q <= cfg_data;
				hiet_pkg::REG_HALF_HEIGHT: half_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic           valid_s1;
	hiet_pkg::req_t req_s1;
	logic           adv_s1;
	logic           batch_free;

	assign adv_s1 = valid_s1 && batch_free;
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// tracked state
	logic [TABLE_DEPTH-1:0]          key_tbl_q;
	logic signed [15:0]              pos_x_q, pos_y_q, rel_x_q, rel_y_q, wheel_q;
	logic [hiet_pkg::BTN_COUNT-1:0]  btn_down_q;

	// single pass over the registered item
	logic                            is_kbd, is_mouse, is_frame, is_query;
	logic                            key_in_range, key_wr, key_make, key_rd, key_down;
	logic [IDX_W-1:0]                key_idx;
	logic signed [15:0]              off_y;
	logic [hiet_pkg::BTN_COUNT-1:0]  btn_down_d, btn_pend_d, btn_press_d;

	always_comb begin
		is_kbd   = req_s1.req_type == hiet_pkg::REQ_KEYBOARD;
		is_mouse = req_s1.req_type == hiet_pkg::REQ_MOUSE;
		is_frame = req_s1.req_type == hiet_pkg::REQ_FRAME;
		is_query = req_s1.req_type == hiet_pkg::REQ_QUERY;
		key_in_range = {9'd0, req_s1.key_code} < KEY_LIMIT;
		key_idx  = req_s1.key_code[IDX_W-1:0];
		key_make = req_s1.key_flags == hiet_pkg::KEY_MAKE;
		key_wr   = is_kbd && (key_make || req_s1.key_flags == hiet_pkg::KEY_BREAK);
		key_rd   = key_in_range && key_tbl_q[key_idx];
		key_down = key_in_range && (key_wr ? key_make : key_rd);
		off_y    = (req_s1.move_y == 16'sh8000) ? 16'sh7fff : 16'(-req_s1.move_y);

		btn_down_d  = btn_down_q;
		btn_pend_d  = '0;
		btn_press_d = '0;
		for (int t = 0; t < hiet_pkg::BTN_COUNT; t++) begin
			if (req_s1.button_flags[2 * (t % hiet_pkg::BTN_PAIRS)]) begin
				btn_pend_d[t]  = !btn_down_q[t];
				btn_press_d[t] = 1'b1;
				btn_down_d[t]  = 1'b1;
			end else if (req_s1.button_flags[2 * (t % hiet_pkg::BTN_PAIRS) + 1]) begin
				btn_pend_d[t]  = btn_down_q[t];
				btn_down_d[t]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_tbl_q  <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			rel_x_q    <= '0;
			rel_y_q    <= '0;
			wheel_q    <= '0;
			btn_down_q <= '0;
		end else if (adv_s1) begin
			if (key_wr && key_in_range) begin
				key_tbl_q[key_idx] <= key_make;
			end
			if (is_mouse) begin
				pos_x_q    <= bounded_add(pos_x_q, req_s1.move_x, half_w_q);
				pos_y_q    <= bounded_add(pos_y_q, off_y, half_h_q);
				rel_x_q    <= req_s1.move_x;
				rel_y_q    <= off_y;
				btn_down_q <= btn_down_d;
				if (req_s1.button_flags[hiet_pkg::WHEEL_BIT]) begin
					wheel_q <= req_s1.wheel_data;
				end
			end
			if (is_frame) begin
				rel_x_q <= '0;
				rel_y_q <= '0;
				wheel_q <= '0;
			end
		end
	end

	// pending results of the applied item
	logic                            bat_valid_q, bat_key_ev_q, bat_key_make_q, bat_kd_q;
	logic [7:0]                      bat_key_q;
	logic [hiet_pkg::BTN_COUNT-1:0]  bat_pend_q, bat_press_q;
	logic                            evt_valid_q;
	hiet_pkg::evt_t                  evt_q, evt_d;
	logic                            out_load, sel_status;
	logic [2:0]                      sel_btn;

	assign out_load   = bat_valid_q && (!evt_valid_q || evt_ready);
	assign sel_status = !bat_key_ev_q && (bat_pend_q == '0);
	assign sel_btn    = first_pend(bat_pend_q);
	assign batch_free = !bat_valid_q || (out_load && sel_status);

	always_comb begin
		evt_d              = '0;
		evt_d.pos_x        = pos_x_q;
		evt_d.pos_y        = pos_y_q;
		evt_d.rel_x        = rel_x_q;
		evt_d.rel_y        = rel_y_q;
		evt_d.wheel        = wheel_q;
		evt_d.event_kind   = hiet_pkg::EV_STATUS;
		evt_d.event_key    = bat_key_q;
		evt_d.key_is_down  = bat_kd_q;
		evt_d.last         = 1'b1;
		if (bat_key_ev_q) begin
			evt_d.event_kind = bat_key_make_q ? hiet_pkg::EV_KEY_PRESSED
				: hiet_pkg::EV_KEY_RELEASED;
			evt_d.last = 1'b0;
		end else if (bat_pend_q != '0) begin
			evt_d.event_kind   = bat_press_q[sel_btn] ? hiet_pkg::EV_BTN_PRESSED
				: hiet_pkg::EV_BTN_RELEASED;
			evt_d.event_key    = '0;
			evt_d.key_is_down  = 1'b0;
			evt_d.button_index = sel_btn;
			evt_d.last         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_valid_q  <= 1'b0;
			bat_key_ev_q <= 1'b0;
			bat_pend_q   <= '0;
			evt_valid_q  <= 1'b0;
		end else begin
			if (adv_s1) begin
				bat_valid_q  <= 1'b1;
				bat_key_ev_q <= key_wr;
				bat_pend_q   <= is_mouse ? btn_pend_d : '0;
			end else if (out_load) begin
				if (sel_status) begin
					bat_valid_q <= 1'b0;
				end else if (bat_key_ev_q) begin
					bat_key_ev_q <= 1'b0;
				end else begin
					bat_pend_q[sel_btn] <= 1'b0;
				end
			end
			if (out_load) begin
				evt_valid_q <= 1'b1;
			end else if (evt_ready) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bat_key_make_q <= key_make;
			bat_press_q    <= btn_press_d;
			bat_key_q      <= (is_kbd || is_query) ? req_s1.key_code : 8'd0;
			bat_kd_q       <= (is_kbd || is_query) && key_down;
		end
		if (out_load) begin
			evt_q <= evt_d;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	// checks
	a_idle_batch_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!bat_valid_q |-> (bat_pend_q == '0 && !bat_key_ev_q))
		else $error("idle batch holds pending events");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (evt.last == (evt.event_kind == hiet_pkg::EV_STATUS)))
		else $error("last flag disagrees with status word");

	a_btn_index: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.event_kind == hiet_pkg::EV_BTN_PRESSED ||
			evt.event_kind == hiet_pkg::EV_BTN_RELEASED)
		|-> evt.button_index < 3'(hiet_pkg::BTN_COUNT))
		else $error("button event index out of range");

	a_key_state: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.event_kind == hiet_pkg::EV_KEY_PRESSED ||
			evt.event_kind == hiet_pkg::EV_KEY_RELEASED)
		|-> evt.key_is_down == (evt.event_kind == hiet_pkg::EV_KEY_PRESSED &&
			{9'd0, evt.event_key} < KEY_LIMIT))
		else $error("key event disagrees with key state");

endmodule
